/* rtl/core/mpcd_pkg.sv */
package mpcd_pkg;

    // Field widths fixed by the converter and the report format.
    localparam int SAMPLE_W  = 12;
    localparam int PERCENT_W = 7;
    localparam int BIT_W     = $clog2(SAMPLE_W);

    // Scaling to percent: (diff * 100) >> 12.
    localparam int PCT_SCALE   = 100;
    localparam int SCALE_W     = 7;
    localparam int SCALE_SHIFT = 12;
    localparam int PROD_W      = SAMPLE_W + SCALE_W;

    // Default window depth.
    localparam int WINDOW_SIZE_DEF = 16;

    // Request codes.
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_POLL   = 1'b1;

    typedef struct packed {
        logic                req_type;
        logic [SAMPLE_W-1:0] sample;
    } t_in_req;

    typedef struct packed {
        logic [PERCENT_W-1:0] percent;
        logic                 changed;
    } t_out_res;

    // Control from the sequencer to the window unit.
    typedef struct packed {
        logic                wr;
        logic [SAMPLE_W-1:0] wr_data;
        logic                start;
    } t_sel_ctl;

    // Status from the window unit back to the sequencer.
    typedef struct packed {
        logic                done;
        logic [SAMPLE_W-1:0] median;
    } t_sel_sts;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SELECT,
        ST_SCALE,
        ST_REPORT
    } t_state;

endpackage

/* rtl/core/mpcd_window.sv */
module mpcd_window
    import mpcd_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_sel_ctl i_ctl,
    output t_sel_sts o_sts
);

    localparam int PTR_W = $clog2(WINDOW_SIZE);
    localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
    localparam int RANK  = WINDOW_SIZE / 2;

    logic [SAMPLE_W-1:0]    r_win [WINDOW_SIZE];
    logic [PTR_W-1:0]       r_ptr;
    logic [WINDOW_SIZE-1:0] r_cand;
    logic [CNT_W-1:0]       r_k;
    logic [BIT_W-1:0]       r_bit;
    logic                   r_busy;
    logic                   r_done;
    logic [SAMPLE_W-1:0]    r_median;

    logic [WINDOW_SIZE-1:0] w_msb;
    logic [WINDOW_SIZE-1:0] w_zero;
    logic [CNT_W-1:0]       n_cnt0;
    logic                   w_take_one;

    // Current top bit of every entry, and the candidates that hold a zero there.
    always_comb begin
        for (int i = 0; i < WINDOW_SIZE; i++) begin
            w_msb[i] = r_win[i][SAMPLE_W-1];
        end
        w_zero = r_cand & ~w_msb;
    end

    // Count of candidates with a zero in the current bit.
    always_comb begin
        n_cnt0 = '0;
        for (int i = 0; i < WINDOW_SIZE; i++) begin
            n_cnt0 = n_cnt0 + CNT_W'(w_zero[i]);
        end
    end

    // The wanted rank lies among the ones when it is not below the zero count.
    assign w_take_one = (r_k >= n_cnt0);

    // Window storage: ring writes, and a one-bit rotation per select step.
    // After SAMPLE_W steps every entry is back in its original alignment.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_SIZE; i++) begin
                r_win[i] <= '0;
            end
            r_ptr <= '0;
        end else if (r_busy) begin
            for (int i = 0; i < WINDOW_SIZE; i++) begin
                r_win[i] <= {r_win[i][SAMPLE_W-2:0], r_win[i][SAMPLE_W-1]};
            end
        end else if (i_ctl.wr) begin
            r_win[r_ptr] <= i_ctl.wr_data;
            if (r_ptr == PTR_W'(WINDOW_SIZE - 1)) begin
                r_ptr <= '0;
            end else begin
                r_ptr <= r_ptr + 1'b1;
            end
        end
    end

    // Radix select, most significant bit first, one bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_bit  <= '0;
            r_k    <= '0;
            r_cand <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start && !r_busy) begin
                r_busy <= 1'b1;
                r_bit  <= '0;
                r_k    <= CNT_W'(RANK);
                r_cand <= '1;
            end else if (r_busy) begin
                if (w_take_one) begin
                    r_k    <= r_k - n_cnt0;
                    r_cand <= r_cand & w_msb;
                end else begin
                    r_cand <= w_zero;
                end
                if (r_bit == BIT_W'(SAMPLE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_bit <= r_bit + 1'b1;
                end
            end
        end
    end

    // The median is built up one result bit per step.
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_median <= {r_median[SAMPLE_W-2:0], w_take_one};
        end
    end

    assign o_sts.done   = r_done;
    assign o_sts.median = r_median;

    // The candidate set never runs empty while a select is in progress.
    a_cand_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cand != '0))
        else $error("select candidate set ran empty");

    // The remaining rank always lies inside the candidate set.
    a_rank_in_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_k < CNT_W'($countones(r_cand))))
        else $error("select rank outside candidate set");

    // Done follows the last select step and nothing else.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("select done without a preceding step");

endmodule

/* rtl/core/median_percent_change_detector_top.sv */
// Sample request: written into the window when accepted, no result; the next request is taken in the next cycle.
// Poll request: result registered after the 12-step bit-serial median select over the
// window (one sample bit per cycle), then the scaling and report stages.
// The input is stalled while a poll is in progress, also while the report waits on the output.
// Reset (synchronous, active low) clears the window, ring pointer, last reported percent,
// zero offset and all handshake state.
module median_percent_change_detector_top
    import mpcd_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in_req             i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_res            o_out_data,
    input  logic                i_cfg_we,
    input  logic [SAMPLE_W-1:0] i_cfg_wdata
);

    t_state               r_state;
    t_state               n_state;
    logic [SAMPLE_W-1:0]  r_zero_offset;
    logic [PERCENT_W-1:0] r_last;
    logic [SAMPLE_W-1:0]  r_diff;
    logic [PERCENT_W-1:0] r_pct;
    logic                 r_out_valid;
    t_out_res             r_out;

    t_sel_ctl             s_ctl;
    t_sel_sts             s_sts;

    logic                 w_accept;
    logic                 w_out_free;
    logic [PROD_W-1:0]    w_prod;
    logic [PERCENT_W:0]   w_delta;
    logic                 w_changed;

    // Requests are taken only while the sequencer is idle.
    assign o_in_stall = (r_state != ST_IDLE);

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Window and median select unit.
    mpcd_window #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (s_ctl),
        .o_sts   (s_sts)
    );

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_offset <= '0;
        end else if (i_cfg_we) begin
            r_zero_offset <= i_cfg_wdata;
        end
    end

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and window control.
    always_comb begin
        n_state       = r_state;
        s_ctl.wr      = 1'b0;
        s_ctl.wr_data = i_in_data.sample;
        s_ctl.start   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in_data.req_type == REQ_POLL) begin
                        s_ctl.start = 1'b1;
                        n_state     = ST_SELECT;
                    end else begin
                        s_ctl.wr = 1'b1;
                    end
                end
            end
            ST_SELECT: begin
                if (s_sts.done) begin
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: begin
                n_state = ST_REPORT;
            end
            ST_REPORT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Offset removal, floored at zero, captured when the median is ready.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SELECT && s_sts.done) begin
            if (s_sts.median > r_zero_offset) begin
                r_diff <= s_sts.median - r_zero_offset;
            end else begin
                r_diff <= '0;
            end
        end
    end

    // Percent scaling: multiply by 100 and drop the low 12 bits.
    assign w_prod = PROD_W'(r_diff) * PROD_W'(PCT_SCALE);

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCALE) begin
            r_pct <= w_prod[SCALE_SHIFT +: PERCENT_W];
        end
    end

    // Deadband: a change is a move of more than one percent.
    always_comb begin
        if (r_pct > r_last) begin
            w_delta = {1'b0, r_pct} - {1'b0, r_last};
        end else begin
            w_delta = {1'b0, r_last} - {1'b0, r_pct};
        end
        w_changed = (w_delta > (PERCENT_W + 1)'(1));
    end

    // Last reported percent.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
        end else if (r_state == ST_REPORT && w_out_free && w_changed) begin
            r_last <= r_pct;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_REPORT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_REPORT && w_out_free) begin
            r_out.percent <= r_pct;
            r_out.changed <= w_changed;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A request that could start a select is never taken while one is running.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_in_stall)
        else $error("request accepted while a poll is in progress");

    // Select completion is only seen while the sequencer waits for it.
    a_done_in_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_sts.done |-> (r_state == ST_SELECT))
        else $error("median ready outside the select phase");

    // A new result appears only from the report stage.
    a_out_from_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_REPORT))
        else $error("result appeared without a report");

    // A flagged change is the value now held as last reported.
    a_changed_tracks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.changed) |-> (r_last == o_out_data.percent))
        else $error("changed result disagrees with last reported percent");

    // Percent stays below one hundred.
    a_percent_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.percent < PERCENT_W'(PCT_SCALE)))
        else $error("percent out of range");

endmodule

/* sim/median_percent_change_detector_top_tb.sv */
`timescale 1ns / 100ps

module median_percent_change_detector_top_tb;
    import mpcd_pkg::*;

    localparam int WIN            = WINDOW_SIZE_DEF;
    localparam int DRAIN_CYCLES   = 24;
    localparam int IDLE_PCT       = 18;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    t_in_req             in_req    = '0;
    logic                out_stall = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [SAMPLE_W-1:0] cfg_wdata = '0;
    logic                in_stall;
    logic                out_valid;
    t_out_res            out_res;

    // Shadow copy of the detector state, advanced on every accepted request.
    logic [SAMPLE_W-1:0]  window_copy [WIN];
    int unsigned          ring_ptr;
    logic [PERCENT_W-1:0] kept_percent;
    logic [SAMPLE_W-1:0]  offset_copy;
    t_out_res             pending_reports [$];

    int errors        = 0;
    int quiet_cycles  = 0;
    bit send_idle_en  = 1'b1;
    bit recv_idle_en  = 1'b1;
    int holdoff_req   = 0;
    int holdoff_seen  = 0;
    int holdoff_left  = 0;

    median_percent_change_detector_top #(
        .WINDOW_SIZE(WIN)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_res),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // A sample goes into the ring; a poll selects the median of a sorted copy,
    // scales it to percent and applies the deadband against the kept value.
    task automatic track_request(input t_in_req r);
        logic [SAMPLE_W-1:0] sorted [$];
        int unsigned         median, diff, pct, delta;
        t_out_res            report;
        if (r.req_type == REQ_SAMPLE) begin
            window_copy[ring_ptr] = r.sample;
            ring_ptr = (ring_ptr + 1) % WIN;
        end else begin
            foreach (window_copy[k]) begin
                sorted.push_back(window_copy[k]);
            end
            sorted.sort();
            median = sorted[WIN / 2];
            diff = (median > offset_copy) ? median - offset_copy : 0;
            pct = (diff * PCT_SCALE) >> SCALE_SHIFT;
            delta = (pct > kept_percent) ? pct - kept_percent : kept_percent - pct;
            report.percent = pct[PERCENT_W-1:0];
            report.changed = (delta > 1);
            if (report.changed) begin
                kept_percent = report.percent;
            end
            pending_reports.push_back(report);
        end
    endtask

    // Predict on each accepted request.
    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall) begin
            track_request(in_req);
        end
    end

    // Compare each accepted report with the oldest prediction.
    always @(posedge clk) begin
        t_out_res want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_reports.size() == 0) begin
                errors++;
                $display("%0t: report with nothing pending: percent %0d changed %0d",
                         $time, out_res.percent, out_res.changed);
            end else begin
                want = pending_reports.pop_front();
                if (out_res.percent !== want.percent) begin
                    errors++;
                    $display("%0t: percent mismatch: expected %0d actual %0d",
                             $time, want.percent, out_res.percent);
                end
                if (out_res.changed !== want.changed) begin
                    errors++;
                    $display("%0t: changed mismatch: expected %0d actual %0d",
                             $time, want.changed, out_res.changed);
                end
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge clk) begin
        if (holdoff_left > 0) begin
            out_stall <= 1'b1;
            holdoff_left <= holdoff_left - 1;
        end else if (holdoff_seen != holdoff_req) begin
            holdoff_seen <= holdoff_req;
            holdoff_left <= HOLDOFF_CYCLES;
            out_stall <= 1'b1;
        end else begin
            out_stall <= recv_idle_en && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Watchdog on cycles without any accepted request or report.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one request, with random idle cycles ahead of it, and hold it until taken.
    // Valid stays high afterwards so back-to-back requests need no extra edge.
    task automatic send_req(input logic kind, input logic [SAMPLE_W-1:0] value);
        t_in_req r;
        r.req_type = kind;
        r.sample = value;
        while (send_idle_en && ($urandom_range(99) < IDLE_PCT)) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req <= r;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
    endtask

    // Park the sender, wait for every pending report, then let the pipeline settle.
    // The first edge lets the predictor record the last accepted request.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_offset(input logic [SAMPLE_W-1:0] value);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        offset_copy = value;
    endtask

    // Mostly a slowly drifting level with small noise, so the deadband is exercised,
    // plus full-range samples, rail values and polls with random ignored sample bits.
    task automatic random_traffic(input int count, input int poll_pct);
        int level;
        int value;
        int roll;
        level = $urandom_range(4095);
        repeat (count) begin
            roll = $urandom_range(99);
            if (roll < poll_pct) begin
                send_req(REQ_POLL, SAMPLE_W'($urandom));
            end else if (roll < 88) begin
                level = level + int'($urandom_range(60)) - 30;
                if (level < 0) level = 0;
                if (level > 4095) level = 4095;
                value = level + int'($urandom_range(40)) - 20;
                if (value < 0) value = 0;
                if (value > 4095) value = 4095;
                send_req(REQ_SAMPLE, value[SAMPLE_W-1:0]);
            end else if (roll < 95) begin
                send_req(REQ_SAMPLE, SAMPLE_W'($urandom));
            end else begin
                send_req(REQ_SAMPLE, $urandom_range(1) ? 12'hFFF : 12'h000);
            end
        end
    endtask

    // A poll straight after reset sees the zero-filled window; its sample field is ignored.
    task automatic test_reset_poll();
        send_req(REQ_POLL, 12'hFFF);
    endtask

    // Nine full-scale samples push the median to full scale while the rest stay zero.
    task automatic test_full_scale();
        repeat (9) send_req(REQ_SAMPLE, 12'hFFF);
        send_req(REQ_POLL, 12'h000);
    endtask

    // Largest offset clamps the percent to zero; zero offset restores full scale.
    task automatic test_offset_extremes();
        write_offset(12'hFFF);
        send_req(REQ_POLL, 12'h5A5);
        write_offset(12'h000);
        send_req(REQ_POLL, 12'hA5A);
    endtask

    task automatic test_random_offsets();
        random_traffic(150, 25);
        write_offset(SAMPLE_W'($urandom));
        random_traffic(120, 25);
        write_offset(12'h800);
        random_traffic(60, 25);
    endtask

    // The receiver holds off while the sender keeps offering, so the block backs up.
    task automatic test_output_holdoff();
        holdoff_req = holdoff_req + 1;
        random_traffic(40, 50);
    endtask

    // The sender stops until every pending report has come back.
    task automatic test_sender_pause();
        random_traffic(20, 25);
        wait_drained();
        random_traffic(20, 25);
    endtask

    // A long stretch with no idling on either side.
    task automatic test_back_to_back();
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        random_traffic(100, 25);
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
    endtask

    initial begin
        foreach (window_copy[k]) begin
            window_copy[k] = '0;
        end
        ring_ptr = 0;
        kept_percent = '0;
        offset_copy = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_poll();
        test_full_scale();
        test_offset_extremes();
        test_random_offsets();
        test_output_holdoff();
        test_sender_pause();
        write_offset(12'h4B0);
        test_back_to_back();
        wait_drained();

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/mpcd_pkg.sv
rtl/core/mpcd_window.sv
rtl/core/median_percent_change_detector_top.sv
sim/median_percent_change_detector_top_tb.sv
